[src/legendre_basis_eval_defines.svh]
// Assertion macros for the Legendre basis evaluator core (lbe_core).
`ifndef LEGENDRE_BASIS_EVAL_DEFINES_SVH
`define LEGENDRE_BASIS_EVAL_DEFINES_SVH

`ifndef SYNTHESIS

// The consequent must hold in the same cycle as the antecedent.
`define LBE_ASSERT_IMPL(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lbe assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define LBE_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lbe assertion failed");

`else

`define LBE_ASSERT_IMPL(name, clk, rst_n, ante, cons)
`define LBE_ASSERT_NEXT(name, clk, rst_n, ante, cons)

`endif

`endif

[src/lbe_pkg.sv]
`default_nettype none

package lbe_pkg;

  localparam int MAX_DEG     = 15;
  localparam int FRAC_BITS   = 16;
  localparam int NORM_BITS   = 16;
  localparam int DEG_W       = 4;
  localparam int X_W         = 18;
  localparam int VAL_W       = 20;
  localparam int U_W         = 20;
  localparam int NORM_W      = 19;
  localparam int MUL_W       = 30;
  localparam int PROD_W      = 2 * MUL_W;
  localparam int ACC_W       = 46;
  localparam int T_W         = 24;
  localparam int NSUM_W      = NORM_BITS + T_W;
  localparam int RECIP_SHIFT = 28;
  localparam int RECIP_W     = 29;
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = VAL_W + DEG_W;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_MAX_DEGREE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INCL_ZERO  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SHIFTED    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_NORMALIZE  = 2'd3;

  localparam logic signed [VAL_W-1:0] VAL_MAX = VAL_W'(2 ** (VAL_W - 1) - 1);
  localparam logic signed [VAL_W-1:0] VAL_MIN = VAL_W'(2 ** (VAL_W - 1));
  localparam logic [T_W-1:0] POS_LIM = T_W'(2 ** (VAL_W - 1) - 1);
  localparam logic [T_W-1:0] NEG_LIM = T_W'(2 ** (VAL_W - 1));
  localparam logic signed [VAL_W-1:0] ONE_VAL = VAL_W'(2 ** FRAC_BITS);
  localparam logic signed [U_W-1:0] ONE_U = U_W'(2 ** FRAC_BITS);

  typedef logic [MAX_DEG:0][NORM_W-1:0] norm_tab_t;

  typedef struct packed {
    logic signed [MUL_W-1:0] a;
    logic signed [MUL_W-1:0] b;
  } mul_op_t;

  typedef struct packed {
    logic [DEG_W-1:0] top;
    logic             incl_zero;
    logic             shifted;
    logic             normalize;
  } cfg_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] value;
    logic [DEG_W-1:0]        degree;
    logic                    last;
    logic                    batch;
  } res_t;

  function automatic longint unsigned isqrt_c(input longint unsigned v_in);
    longint unsigned v;
    longint unsigned r;
    longint unsigned b;
    int i;
    v = v_in;
    r = 0;
    b = 64'h4000_0000_0000_0000;
    for (i = 0; i < 32; i++) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic norm_tab_t build_norm_tab(input logic sh);
    norm_tab_t tab;
    longint unsigned rad;
    longint unsigned r;
    int d;
    tab = '0;
    for (d = 0; d <= MAX_DEG; d++) begin
      rad = longint'(2 * d + 1);
      rad = rad << (2 * NORM_BITS);
      r = isqrt_c(sh ? rad * 4 : rad * 2);
      tab[d] = NORM_W'((r + 1) >> 1);
    end
    return tab;
  endfunction

  localparam norm_tab_t NORM_TAB_PLAIN = build_norm_tab(1'b0);
  localparam norm_tab_t NORM_TAB_SHIFT = build_norm_tab(1'b1);

  // Reciprocals ceil(2^28 / d): exact floor division for quotients of 24-bit values.
  function automatic logic [RECIP_W-1:0] recip(input logic [DEG_W-1:0] d);
    logic [RECIP_W-1:0] r;
    case (d)
      4'd2:    r = 29'd134217728;
      4'd3:    r = 29'd89478486;
      4'd4:    r = 29'd67108864;
      4'd5:    r = 29'd53687092;
      4'd6:    r = 29'd44739243;
      4'd7:    r = 29'd38347923;
      4'd8:    r = 29'd33554432;
      4'd9:    r = 29'd29826162;
      4'd10:   r = 29'd26843546;
      4'd11:   r = 29'd24403224;
      4'd12:   r = 29'd22369622;
      4'd13:   r = 29'd20648882;
      4'd14:   r = 29'd19173962;
      4'd15:   r = 29'd17895698;
      default: r = 29'd268435456;
    endcase
    return r;
  endfunction

  // Applies the sign to a magnitude and clamps it to the output range.
  function automatic logic signed [VAL_W-1:0] sat_mag(input logic neg,
                                                      input logic [T_W-1:0] q);
    logic signed [VAL_W-1:0] r;
    if (!neg) begin
      r = (q > POS_LIM) ? VAL_MAX : $signed(q[VAL_W-1:0]);
    end else begin
      r = (q > NEG_LIM) ? VAL_MIN : $signed(VAL_W'(~q[VAL_W-1:0] + 1'b1));
    end
    return r;
  endfunction

endpackage

`default_nettype wire

[src/legendre_basis_eval.sv]
// Legendre basis evaluator.
// One beat on the in_ channel carries a sample point x (signed, 16 fraction bits)
// and in_tlast marks the last point of a batch. For each point the block sends
// P_0 = 1 first when degree zero is enabled, then P_1 .. P_D on the out_ channel,
// D being the max_degree register. out_tlast marks the final beat of a point and
// out_tuser repeats the point's in_tlast on that beat.
// All arithmetic runs on one shared 30 x 30 multiplier under a sequencer, so a
// point is taken only while the block is idle. Each degree of one or more runs
// three multiplies, a subtract, a round, a reciprocal divide and a saturate,
// normalization adds a multiply and a round per value, and the sequencer idles
// to take the next point. With nothing to send, a point is taken and discarded.
// A stalled receiver holds the output register, and the sequencer waits on the
// finished value until the register frees up; nothing is dropped.
// Configuration writes go through cfg_we, cfg_index and cfg_wdata while idle;
// the user must keep to this, as the block does not enforce it. Reset (rst_n
// low, synchronous) returns the sequencer to idle, empties the output register
// and restores max_degree 4, degree zero on, plain domain and no normalization.
`default_nettype none

module legendre_basis_eval (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  input  logic [lbe_pkg::IN_TDATA_W-1:0]        in_tdata,   // sample_point [17:0]
  input  logic                                  in_tlast,
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  output logic [lbe_pkg::OUT_TDATA_W-1:0]       out_tdata,  // poly_value [19:0], poly_degree [23:20]
  output logic                                  out_tlast,
  output logic                                  out_tuser,  // batch_end [0]
  input  logic                                  cfg_we,
  input  logic [lbe_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [lbe_pkg::CFG_DATA_W-1:0]        cfg_wdata
);
  import lbe_pkg::*;

  logic [DEG_W-1:0] max_degree_r, max_degree_nxt;
  logic             incl_zero_r, incl_zero_nxt;
  logic             shifted_r, shifted_nxt;
  logic             normalize_r, normalize_nxt;
  logic             out_valid_r, out_valid_nxt;
  res_t             out_r, out_nxt;

  cfg_t                    cfg;
  mul_op_t                 op;
  logic signed [PROD_W-1:0] prod;
  logic                    res_valid;
  logic                    res_ready;
  res_t                    res;
  logic                    res_fire;

  always_comb begin
    max_degree_nxt = max_degree_r;
    incl_zero_nxt  = incl_zero_r;
    shifted_nxt    = shifted_r;
    normalize_nxt  = normalize_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_MAX_DEGREE: max_degree_nxt = cfg_wdata[DEG_W-1:0];
        CFG_INCL_ZERO:  incl_zero_nxt  = cfg_wdata[0];
        CFG_SHIFTED:    shifted_nxt    = cfg_wdata[0];
        CFG_NORMALIZE:  normalize_nxt  = cfg_wdata[0];
        default: begin
          max_degree_nxt = max_degree_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_degree_r <= DEG_W'(4);
      incl_zero_r  <= 1'b1;
      shifted_r    <= 1'b0;
      normalize_r  <= 1'b0;
    end else begin
      max_degree_r <= max_degree_nxt;
      incl_zero_r  <= incl_zero_nxt;
      shifted_r    <= shifted_nxt;
      normalize_r  <= normalize_nxt;
    end
  end

  assign cfg.top       = (max_degree_r > MAX_DEG) ? DEG_W'(MAX_DEG) : max_degree_r;
  assign cfg.incl_zero = incl_zero_r;
  assign cfg.shifted   = shifted_r;
  assign cfg.normalize = normalize_r;

  lbe_mul u_mul (
    .clk  (clk),
    .op   (op),
    .prod (prod)
  );

  lbe_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .start      (in_tvalid & in_tready),
    .sample     ($signed(in_tdata[X_W-1:0])),
    .last_point (in_tlast),
    .in_ready   (in_tready),
    .prod       (prod),
    .op         (op),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (res)
  );

  assign res_ready = !out_valid_r || out_tready;
  assign res_fire  = res_valid && res_ready;

  always_comb begin
    out_nxt       = res_fire ? res : out_r;
    out_valid_nxt = res_fire ? 1'b1 : (out_tready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_r.degree, out_r.value};
  assign out_tlast  = out_r.last;
  assign out_tuser  = out_r.batch;

endmodule

`default_nettype wire

[src/lbe_mul.sv]
`default_nettype none

module lbe_mul (
  input  logic                               clk,
  input  lbe_pkg::mul_op_t                   op,
  output logic signed [lbe_pkg::PROD_W-1:0]  prod
);
  import lbe_pkg::*;

  logic signed [PROD_W-1:0] prod_nxt;
  logic signed [PROD_W-1:0] prod_r;

  always_comb begin
    prod_nxt = PROD_W'($signed(op.a)) * PROD_W'($signed(op.b));
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
  end

  assign prod = prod_r;

endmodule

`default_nettype wire

[src/lbe_core.sv]
`default_nettype none
`include "legendre_basis_eval_defines.svh"

module lbe_core (
  input  logic                               clk,
  input  logic                               rst_n,
  input  lbe_pkg::cfg_t                      cfg,
  input  logic                               start,
  input  logic signed [lbe_pkg::X_W-1:0]     sample,
  input  logic                               last_point,
  output logic                               in_ready,
  input  logic signed [lbe_pkg::PROD_W-1:0]  prod,
  output lbe_pkg::mul_op_t                   op,
  output logic                               res_valid,
  input  logic                               res_ready,
  output lbe_pkg::res_t                      res
);
  import lbe_pkg::*;

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_ZERO = 4'd1;
  localparam logic [3:0] ST_MA   = 4'd2;
  localparam logic [3:0] ST_MB   = 4'd3;
  localparam logic [3:0] ST_MC   = 4'd4;
  localparam logic [3:0] ST_SUB  = 4'd5;
  localparam logic [3:0] ST_RND  = 4'd6;
  localparam logic [3:0] ST_DIV  = 4'd7;
  localparam logic [3:0] ST_SAT  = 4'd8;
  localparam logic [3:0] ST_NMUL = 4'd9;
  localparam logic [3:0] ST_NRND = 4'd10;
  localparam logic [3:0] ST_EMIT = 4'd11;

  logic [3:0]              state_r, state_nxt;
  logic [DEG_W-1:0]        deg_r, deg_nxt;
  logic signed [U_W-1:0]   u_r, u_nxt;
  logic signed [VAL_W-1:0] p1_r, p1_nxt;
  logic signed [VAL_W-1:0] p2_r, p2_nxt;
  logic signed [VAL_W-1:0] val_r, val_nxt;
  logic signed [ACC_W-1:0] acc_r, acc_nxt;
  logic [T_W-1:0]          t_r, t_nxt;
  logic                    neg_r, neg_nxt;
  logic                    last_pt_r, last_pt_nxt;

  logic [DEG_W:0]          odd_w;
  logic [DEG_W-1:0]        prev_w;
  logic [NORM_W-1:0]       norm_w;
  logic [ACC_W-1:0]        half_w;
  logic [ACC_W-1:0]        tsum_w;
  logic [NSUM_W-1:0]       nsum_w;
  logic [NSUM_W-1:0]       nprod_w;
  logic                    nneg_w;
  logic                    last_w;

  assign odd_w   = {deg_r, 1'b0} - (DEG_W + 1)'(1);
  assign prev_w  = deg_r - DEG_W'(1);
  assign norm_w  = cfg.shifted ? NORM_TAB_SHIFT[deg_r] : NORM_TAB_PLAIN[deg_r];
  assign half_w  = ACC_W'(deg_r) << (FRAC_BITS - 1);
  assign tsum_w  = acc_r[ACC_W-1] ? (half_w - $unsigned(acc_r))
                                  : ($unsigned(acc_r) + half_w);
  assign nprod_w = prod[NSUM_W-1:0];
  assign nneg_w  = prod[PROD_W-1];
  assign nsum_w  = nneg_w ? (NSUM_W'(2 ** (NORM_BITS - 1)) - nprod_w)
                          : (nprod_w + NSUM_W'(2 ** (NORM_BITS - 1)));
  assign last_w  = (deg_r == cfg.top);

  always_comb begin
    op = '0;
    case (state_r)
      ST_MA: begin
        op.a = {{(MUL_W - DEG_W - 1){1'b0}}, odd_w};
        op.b = MUL_W'(p1_r);
      end
      ST_MB: begin
        op.a = prod[MUL_W-1:0];
        op.b = MUL_W'(u_r);
      end
      ST_MC: begin
        op.a = {{(MUL_W - DEG_W){1'b0}}, prev_w};
        op.b = MUL_W'(p2_r);
      end
      ST_DIV: begin
        op.a = {{(MUL_W - T_W){1'b0}}, t_r};
        op.b = {{(MUL_W - RECIP_W){1'b0}}, recip(deg_r)};
      end
      ST_NMUL: begin
        op.a = MUL_W'(val_r);
        op.b = {{(MUL_W - NORM_W){1'b0}}, norm_w};
      end
      default: begin
        op = '0;
      end
    endcase
  end

  always_comb begin
    state_nxt   = state_r;
    deg_nxt     = deg_r;
    u_nxt       = u_r;
    p1_nxt      = p1_r;
    p2_nxt      = p2_r;
    val_nxt     = val_r;
    acc_nxt     = acc_r;
    t_nxt       = t_r;
    neg_nxt     = neg_r;
    last_pt_nxt = last_pt_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          u_nxt       = cfg.shifted ? ((U_W'(sample) <<< 1) - ONE_U) : U_W'(sample);
          last_pt_nxt = last_point;
          p1_nxt      = ONE_VAL;
          p2_nxt      = '0;
          if (cfg.incl_zero) begin
            deg_nxt   = '0;
            state_nxt = ST_ZERO;
          end else if (cfg.top != '0) begin
            deg_nxt   = DEG_W'(1);
            state_nxt = ST_MA;
          end
        end
      end
      ST_ZERO: begin
        val_nxt   = ONE_VAL;
        state_nxt = cfg.normalize ? ST_NMUL : ST_EMIT;
      end
      ST_MA: state_nxt = ST_MB;
      ST_MB: state_nxt = ST_MC;
      ST_MC: begin
        acc_nxt   = ACC_W'(prod);
        state_nxt = ST_SUB;
      end
      ST_SUB: begin
        acc_nxt   = acc_r - (ACC_W'(prod) <<< FRAC_BITS);
        state_nxt = ST_RND;
      end
      ST_RND: begin
        neg_nxt   = acc_r[ACC_W-1];
        t_nxt     = (|tsum_w[ACC_W-1:FRAC_BITS+T_W]) ? '1
                                                     : tsum_w[FRAC_BITS+T_W-1:FRAC_BITS];
        state_nxt = ST_DIV;
      end
      ST_DIV: state_nxt = ST_SAT;
      ST_SAT: begin
        val_nxt   = sat_mag(neg_r, prod[RECIP_SHIFT+T_W-1:RECIP_SHIFT]);
        p1_nxt    = sat_mag(neg_r, prod[RECIP_SHIFT+T_W-1:RECIP_SHIFT]);
        p2_nxt    = p1_r;
        state_nxt = cfg.normalize ? ST_NMUL : ST_EMIT;
      end
      ST_NMUL: state_nxt = ST_NRND;
      ST_NRND: begin
        val_nxt   = sat_mag(nneg_w, nsum_w[NSUM_W-1:NORM_BITS]);
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (res_ready) begin
          if (last_w) begin
            state_nxt = ST_IDLE;
          end else begin
            deg_nxt   = deg_r + DEG_W'(1);
            state_nxt = ST_MA;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    deg_r     <= deg_nxt;
    u_r       <= u_nxt;
    p1_r      <= p1_nxt;
    p2_r      <= p2_nxt;
    val_r     <= val_nxt;
    acc_r     <= acc_nxt;
    t_r       <= t_nxt;
    neg_r     <= neg_nxt;
    last_pt_r <= last_pt_nxt;
  end

  assign in_ready   = (state_r == ST_IDLE);
  assign res_valid  = (state_r == ST_EMIT);
  assign res.value  = val_r;
  assign res.degree = deg_r;
  assign res.last   = last_w;
  assign res.batch  = last_w & last_pt_r;

  `LBE_ASSERT_IMPL(a_first_step_seed, clk, rst_n, (state_r == ST_MA) && (deg_r == DEG_W'(1)), (p1_r == ONE_VAL) && (p2_r == '0))
  `LBE_ASSERT_IMPL(a_quotient_fits, clk, rst_n, state_r == ST_SAT, prod[PROD_W-1:RECIP_SHIFT+T_W] == '0)
  `LBE_ASSERT_IMPL(a_degree_bound, clk, rst_n, state_r != ST_IDLE, deg_r <= cfg.top)
  `LBE_ASSERT_NEXT(a_next_degree, clk, rst_n, (state_r == ST_EMIT) && res_ready && !last_w, (state_r == ST_MA) && (deg_r == $past(deg_r) + DEG_W'(1)))

endmodule

`default_nettype wire
